// ===== design/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types, constants and the checksum verdict for the servo deframer.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam logic [7:0] CK_MASK       = 8'hFE;
    localparam logic [7:0] MIN_SIZE      = 8'h07;
    localparam logic [7:0] MAX_SIZE_RST  = 8'd64;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_CK1_BAD  = 2'd1;
    localparam status_t ST_CK2_BAD  = 2'd2;
    localparam status_t ST_BAD_SIZE = 2'd3;

    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] command;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       data_valid;
        logic       is_last;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // checksum1 is judged first; checksum2 only counts when checksum1 matched
    function automatic status_t verdict(input logic [7:0] xor_val,
                                        input logic [7:0] ck1,
                                        input logic [7:0] ck2);
        status_t st;
        if ((xor_val & CK_MASK) != ck1)
            st = ST_CK1_BAD;
        else if ((~xor_val & CK_MASK) != ck2)
            st = ST_CK2_BAD;
        else
            st = ST_OK;
        return st;
    endfunction

endpackage

// ===== design/srd_parser.sv =====
// ----------------------------------------------------------------------------
// srd_parser
// Front end: hunts the header, captures packet fields and classifies bytes.
// ----------------------------------------------------------------------------
module srd_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    output logic            push,
    output srd_pkg::result_t push_data
);
    import srd_pkg::*;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_SIZE = 3'd1;
    localparam logic [2:0] PH_ID   = 3'd2;
    localparam logic [2:0] PH_CMD  = 3'd3;
    localparam logic [2:0] PH_CK1  = 3'd4;
    localparam logic [2:0] PH_CK2  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       prev_ff_reg, prev_ff_next;
    logic [7:0] size_reg, size_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] ck1_reg, ck1_next;
    logic [7:0] ck2_reg, ck2_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] max_size_reg;

    logic [7:0] payload_len;
    logic [8:0] idx_plus;
    logic       data_last;

    assign payload_len = size_reg - MIN_SIZE;
    assign idx_plus    = {1'b0, count_reg} + 9'd1;
    assign data_last   = (idx_plus >= {1'b0, payload_len});

    always_comb
    begin
        state_next   = state_reg;
        prev_ff_next = prev_ff_reg;
        size_next    = size_reg;
        id_next      = id_reg;
        cmd_next     = cmd_reg;
        ck1_next     = ck1_reg;
        ck2_next     = ck2_reg;
        xor_next     = xor_reg;
        count_next   = count_reg;
        push         = 1'b0;
        push_data    = '0;
        if (accept)
        begin
            unique case (state_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR_BYTE && prev_ff_reg)
                    begin
                        state_next   = PH_SIZE;
                        prev_ff_next = 1'b0;
                    end
                    else
                    begin
                        prev_ff_next = (rx_byte == HDR_BYTE);
                    end
                end
                PH_SIZE:
                begin
                    if (rx_byte < MIN_SIZE || rx_byte > max_size_reg)
                    begin
                        push              = 1'b1;
                        push_data.is_last = 1'b1;
                        push_data.status  = ST_BAD_SIZE;
                        state_next        = PH_HUNT;
                        prev_ff_next      = 1'b0;
                    end
                    else
                    begin
                        size_next  = rx_byte;
                        xor_next   = rx_byte;
                        count_next = '0;
                        state_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    id_next    = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    state_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    state_next = PH_CK1;
                end
                PH_CK1:
                begin
                    ck1_next   = rx_byte;
                    state_next = PH_CK2;
                end
                PH_CK2:
                begin
                    ck2_next = rx_byte;
                    if (size_reg <= MIN_SIZE)
                    begin
                        // empty payload: this byte closes the packet
                        push               = 1'b1;
                        push_data.servo_id = id_reg;
                        push_data.command  = cmd_reg;
                        push_data.is_last  = 1'b1;
                        push_data.status   = verdict(xor_reg, ck1_reg, rx_byte);
                        state_next         = PH_HUNT;
                        prev_ff_next       = 1'b0;
                    end
                    else
                    begin
                        state_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    xor_next             = xor_reg ^ rx_byte;
                    count_next           = idx_plus[7:0];
                    push                 = 1'b1;
                    push_data.servo_id   = id_reg;
                    push_data.command    = cmd_reg;
                    push_data.data_byte  = rx_byte;
                    push_data.data_index = count_reg;
                    push_data.data_valid = 1'b1;
                    if (data_last)
                    begin
                        push_data.is_last = 1'b1;
                        push_data.status  = verdict(xor_reg ^ rx_byte, ck1_reg, ck2_reg);
                        state_next        = PH_HUNT;
                        prev_ff_next      = 1'b0;
                    end
                end
                default:
                begin
                    state_next   = PH_HUNT;
                    prev_ff_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PH_HUNT;
            prev_ff_reg  <= 1'b0;
            size_reg     <= '0;
            id_reg       <= '0;
            cmd_reg      <= '0;
            ck1_reg      <= '0;
            ck2_reg      <= '0;
            xor_reg      <= '0;
            count_reg    <= '0;
            max_size_reg <= MAX_SIZE_RST;
        end
        else
        begin
            state_reg   <= state_next;
            prev_ff_reg <= prev_ff_next;
            size_reg    <= size_next;
            id_reg      <= id_next;
            cmd_reg     <= cmd_next;
            ck1_reg     <= ck1_next;
            ck2_reg     <= ck2_next;
            xor_reg     <= xor_next;
            count_reg   <= count_next;
            if (cfg_wr_en)
                max_size_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== design/srd_fifo.sv =====
// ----------------------------------------------------------------------------
// srd_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module srd_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srd_pkg::result_t     push_data,
    input  logic                 pop,
    output srd_pkg::result_t     head,
    output srd_pkg::fifo_status_t status
);
    import srd_pkg::*;

    result_t           mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(FIFO_DEPTH);

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_DEPTH);
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("result queue underflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && count_reg != CNT_DEPTH) |-> wr_ptr_reg != rd_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/srd_out_stage.sv =====
// ----------------------------------------------------------------------------
// srd_out_stage
// Back end: output register that drains the result queue.
// ----------------------------------------------------------------------------
module srd_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  srd_pkg::result_t      head,
    input  srd_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output srd_pkg::result_t      out_data
);
    import srd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // load whenever the register is empty or its beat leaves this cycle
    assign pop       = !fifo_status.empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

endmodule

// ===== design/servo_response_deframer.sv =====
// ----------------------------------------------------------------------------
// servo_response_deframer
// Deframes smart-servo reply packets from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte per
//   beat. The block hunts for two 0xFF header bytes, then captures size, id,
//   command, checksum1 and checksum2, then size-7 payload bytes.
//   Output channel (out_valid / out_stall / result fields) gives one beat per
//   payload byte, the last of which carries the verdict; a bad size byte gives
//   one last beat with status 3 at once, and an empty payload closes on the
//   checksum2 byte.
//   cfg_wr_en / cfg_wr_data write max_packet_bytes (reset 64); write it only
//   while the block is idle.
// Throughput: one byte per cycle while in_stall is low, as the parser updates
//   on every accepted byte. Path: the parser writes each result into the
//   4-entry queue at the edge that accepts its byte; the output register then
//   loads from the queue once it is empty or its beat leaves.
// Reset: the parser returns to header hunt, the queue and output empty.
// Receiver stall: the output beat holds; the queue absorbs up to four more
//   results, and in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module servo_response_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] servo_id,
    output logic [7:0] command,
    output logic [7:0] data_byte,
    output logic [7:0] data_index,
    output logic       data_valid,
    output logic       is_last,
    output logic [1:0] status
);
    import srd_pkg::*;

    logic         accept;
    logic         push;
    logic         pop;
    result_t      push_data;
    result_t      head;
    result_t      out_data;
    fifo_status_t fifo_status;

    // hold input while the queue has no room; full comes from a registered count
    assign in_stall = fifo_status.full;
    assign accept   = in_valid && !in_stall;

    srd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .push        (push),
        .push_data   (push_data)
    );

    srd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (fifo_status)
    );

    srd_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    assign servo_id   = out_data.servo_id;
    assign command    = out_data.command;
    assign data_byte  = out_data.data_byte;
    assign data_index = out_data.data_index;
    assign data_valid = out_data.data_valid;
    assign is_last    = out_data.is_last;
    assign status     = out_data.status;

endmodule
